// ----- sv/mlts_pkg.sv -----
// shared constants and types for the mesh light top-k selector
`default_nettype none
package mlts_pkg;
    localparam int MAX_LIGHTS_DEF = 4;
    localparam logic [15:0] ONE_Q12 = 16'd4096;
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] inf;
        logic        first;
        logic        last;
    } cand_t;
endpackage
`default_nettype wire

// ----- sv/mlts_front.sv -----
// front end: influence of one light on one mesh (sqrt and divide units)
`default_nettype none
module mlts_front
    import mlts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] mesh_x,
    input  wire logic signed [23:0] mesh_y,
    input  wire logic signed [23:0] mesh_z,
    input  wire logic [23:0]        bbox_diagonal,
    input  wire logic signed [23:0] light_x,
    input  wire logic signed [23:0] light_y,
    input  wire logic signed [23:0] light_z,
    input  wire logic [23:0]        light_range,
    input  wire logic               directional,
    input  wire logic [15:0]        light_id,
    input  wire logic               first,
    input  wire logic               last,
    output logic                    cand_valid,
    output cand_t                   cand,
    input  wire logic               cand_ready
);
    typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_SQRT, S_PREP, S_DIV, S_OUT} state_t;

    state_t             state_reg;
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic [49:0]        sx_reg, sy_reg, sz_reg;
    logic [53:0]        rem_reg;
    logic [27:0]        root_reg;
    logic [55:0]        v_reg;
    logic [4:0]         cnt_reg;
    logic [25:0]        pos_reg;
    logic [24:0]        den_reg;
    logic [38:0]        num_reg;
    logic [25:0]        drem_reg;
    logic [38:0]        quo_reg;
    logic [5:0]         dcnt_reg;
    logic               zero_reg, dir_reg;
    logic [15:0]        id_reg;
    logic               first_reg, last_reg;
    cand_t              cand_reg;

    logic [53:0] trial;
    logic [53:0] rem_sh;
    logic [25:0] drem_sh;
    logic [26:0] twice_dist;

    assign busy = (state_reg != S_IDLE);
    assign cand_valid = (state_reg == S_OUT);
    assign cand = cand_reg;
    assign rem_sh = {rem_reg[51:0], v_reg[55:54]};
    assign trial = {24'd0, root_reg, 2'b01};
    assign drem_sh = {drem_reg[24:0], num_reg[38]};
    assign twice_dist = root_reg[26:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        dx_reg <= 25'(light_x) - 25'(mesh_x);
                        dy_reg <= 25'(light_y) - 25'(mesh_y);
                        dz_reg <= 25'(light_z) - 25'(mesh_z);
                        pos_reg <= {1'b0, light_range, 1'b0} + {2'b0, bbox_diagonal};
                        den_reg <= {light_range, 1'b0};
                        zero_reg <= (light_range == 24'd0);
                        dir_reg <= directional;
                        id_reg <= light_id;
                        first_reg <= first;
                        last_reg <= last;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sx_reg <= 50'(dx_reg * dx_reg);
                    sy_reg <= 50'(dy_reg * dy_reg);
                    sz_reg <= 50'(dz_reg * dz_reg);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    v_reg <= {4'd0, sx_reg + sy_reg + sz_reg, 2'b00};
                    rem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= (dir_reg || zero_reg) ? S_OUT : S_SQRT;
                    cand_reg.id <= id_reg;
                    cand_reg.inf <= dir_reg ? ONE_Q12 : 16'd0;
                    cand_reg.first <= first_reg;
                    cand_reg.last <= last_reg;
                end
                S_SQRT:
                begin
                    v_reg <= {v_reg[53:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg <= rem_sh - trial;
                        root_reg <= {root_reg[26:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[26:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd27)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if ({1'b0, pos_reg} <= twice_dist)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        num_reg <= {1'b0, 26'(27'(pos_reg) - twice_dist), 12'd0};
                        drem_reg <= '0;
                        quo_reg <= '0;
                        dcnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[37:0], 1'b0};
                    if (drem_sh >= {1'b0, den_reg})
                    begin
                        drem_reg <= drem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[37:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh;
                        quo_reg <= {quo_reg[37:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd38)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (cand_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_DIV && dcnt_reg == 6'd38)
            begin
                cand_reg.inf <= (quo_reg[37:15] != 23'd0) ? 16'hFFFF
                              : (drem_sh >= {1'b0, den_reg} ? {quo_reg[14:0], 1'b1}
                                                           : {quo_reg[14:0], 1'b0});
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/mlts_queue.sv -----
// short transaction queue between front and back
`default_nettype none
module mlts_queue
    import mlts_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  cand_t      in_data,
    output logic       in_ready,
    output logic       out_valid,
    output cand_t      out_data,
    input  wire logic  out_ready
);
    cand_t       mem_reg [FIFO_DEPTH];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- sv/mlts_back.sv -----
// back end: kept list update and ordered emission
`default_nettype none
module mlts_back
    import mlts_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic  q_valid,
    input  cand_t      q_data,
    output logic       q_ready,
    output logic       result_valid,
    output logic [15:0] sel_light_id,
    output logic [15:0] sel_influence,
    output logic [1:0]  rank,
    output logic [2:0]  kept_count,
    output logic        none_kept,
    output logic        last_result
);
    localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int NW = $clog2(MAX_LIGHTS + 1);

    typedef enum logic [1:0] {B_IDLE, B_UPD, B_EMIT} state_t;

    state_t           state_reg;
    logic [15:0]      min_reg;
    logic [15:0]      id_reg [MAX_LIGHTS];
    logic [15:0]      inf_reg [MAX_LIGHTS];
    logic [NW-1:0]    num_reg;
    logic [MAX_LIGHTS-1:0] used_reg;
    logic [NW-1:0]    k_reg;
    cand_t            c_reg;
    logic [IW-1:0]    mi_reg;
    logic [IW-1:0]    scan_reg;

    logic [IW-1:0] best;
    logic          found;

    assign q_ready = (state_reg == B_IDLE);

    always_comb
    begin
        best = '0;
        found = 1'b0;
        for (int i = 0; i < MAX_LIGHTS; i++)
        begin
            if (NW'(i) < num_reg && !used_reg[i]
                && (!found || inf_reg[i] > inf_reg[best]))
            begin
                best = IW'(i);
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            min_reg <= '0;
            num_reg <= '0;
            result_valid <= 1'b0;
            for (int i = 0; i < MAX_LIGHTS; i++)
            begin
                id_reg[i] <= '0;
                inf_reg[i] <= '0;
            end
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we) min_reg <= cfg_wdata;
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        c_reg <= q_data;
                        if (q_data.first) num_reg <= '0;
                        mi_reg <= '0;
                        scan_reg <= '0;
                        state_reg <= B_UPD;
                    end
                end
                B_UPD:
                begin
                    if (c_reg.inf <= min_reg)
                    begin
                        used_reg <= '0;
                        k_reg <= '0;
                        state_reg <= c_reg.last ? B_EMIT : B_IDLE;
                    end
                    else if (num_reg < NW'(MAX_LIGHTS))
                    begin
                        id_reg[num_reg[IW-1:0]] <= c_reg.id;
                        inf_reg[num_reg[IW-1:0]] <= c_reg.inf;
                        num_reg <= num_reg + NW'(1);
                        used_reg <= '0;
                        k_reg <= '0;
                        state_reg <= c_reg.last ? B_EMIT : B_IDLE;
                    end
                    else if (scan_reg != IW'(MAX_LIGHTS - 1))
                    begin
                        scan_reg <= scan_reg + IW'(1);
                        if (inf_reg[scan_reg + IW'(1)] < inf_reg[mi_reg])
                            mi_reg <= scan_reg + IW'(1);
                    end
                    else
                    begin
                        if (c_reg.inf > inf_reg[mi_reg])
                        begin
                            for (int i = 0; i < MAX_LIGHTS - 1; i++)
                            begin
                                if (IW'(i) >= mi_reg)
                                begin
                                    id_reg[i] <= id_reg[i+1];
                                    inf_reg[i] <= inf_reg[i+1];
                                end
                            end
                            id_reg[MAX_LIGHTS-1] <= c_reg.id;
                            inf_reg[MAX_LIGHTS-1] <= c_reg.inf;
                        end
                        used_reg <= '0;
                        k_reg <= '0;
                        state_reg <= c_reg.last ? B_EMIT : B_IDLE;
                    end
                end
                B_EMIT:
                begin
                    result_valid <= 1'b1;
                    if (num_reg == '0)
                    begin
                        sel_light_id <= '0;
                        sel_influence <= '0;
                        rank <= '0;
                        kept_count <= '0;
                        none_kept <= 1'b1;
                        last_result <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        used_reg[best] <= 1'b1;
                        sel_light_id <= id_reg[best];
                        sel_influence <= inf_reg[best];
                        rank <= 2'(k_reg);
                        kept_count <= 3'(num_reg);
                        none_kept <= 1'b0;
                        last_result <= (k_reg + NW'(1) == num_reg);
                        k_reg <= k_reg + NW'(1);
                        if (k_reg + NW'(1) == num_reg) state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/mesh_light_topk_selector.sv -----
// top level of the mesh light top-k selector
// The front end keeps busy high while it works on a light. A point light within reach
// goes through a 28-step bit-serial square root and a 39-step restoring divider; a point
// light out of reach skips the divider, and a directional or zero-range light skips both.
// The back end updates its kept list once per light and then emits one result per
// cycle, and a two-entry queue lets the front work on the next light meanwhile.
// Results appear one per cycle on result_valid and must be taken when shown.
`default_nettype none
module mesh_light_topk_selector
    import mlts_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] mesh_x,
    input  wire logic signed [23:0] mesh_y,
    input  wire logic signed [23:0] mesh_z,
    input  wire logic [23:0]        bbox_diagonal,
    input  wire logic signed [23:0] light_x,
    input  wire logic signed [23:0] light_y,
    input  wire logic signed [23:0] light_z,
    input  wire logic [23:0]        light_range,
    input  wire logic               directional,
    input  wire logic [15:0]        light_id,
    input  wire logic               first,
    input  wire logic               last,
    output logic                    result_valid,
    output logic [15:0]             sel_light_id,
    output logic [15:0]             sel_influence,
    output logic [1:0]              rank,
    output logic [2:0]              kept_count,
    output logic                    none_kept,
    output logic                    last_result
);
    logic  f_valid, f_ready, q_valid, q_ready;
    cand_t f_data, q_data;

    mlts_front u_front (
        .clk, .rst_n, .start, .busy,
        .mesh_x, .mesh_y, .mesh_z, .bbox_diagonal,
        .light_x, .light_y, .light_z, .light_range,
        .directional, .light_id, .first, .last,
        .cand_valid(f_valid), .cand(f_data), .cand_ready(f_ready)
    );

    mlts_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_data(f_data), .in_ready(f_ready),
        .out_valid(q_valid), .out_data(q_data), .out_ready(q_ready)
    );

    mlts_back #(.MAX_LIGHTS(MAX_LIGHTS)) u_back (
        .clk, .rst_n, .cfg_we, .cfg_wdata,
        .q_valid, .q_data, .q_ready,
        .result_valid, .sel_light_id, .sel_influence, .rank,
        .kept_count, .none_kept, .last_result
    );
endmodule
`default_nettype wire
